/* hdl/indexed_list_insert_delete_defines.svh */
// Assertion macros shared by the indexed list RTL.
// Included by the top level, which carries concurrent assertions; depends on nothing.
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define ILID_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ILID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ilid_pkg.sv */
// Shared types and constants for the indexed list block.
// Used by the channel interfaces, the list cell and the top level; no dependencies.
`timescale 1ns / 1ps

package ilid_pkg;

   localparam int FUNC_W  = 2;
   localparam int POS_W   = 6;
   localparam int ENTRY_W = 32;
   localparam int COUNT_W = 6;

   localparam int DEPTH_DEFAULT = 32;

   localparam logic [FUNC_W-1:0] OP_GET    = 2'd0;
   localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

   typedef logic signed [ENTRY_W-1:0] entry_type;

   // Shift command broadcast to every cell of the row.
   typedef struct packed {
      logic               ins_en;
      logic               del_en;
      logic [POS_W-1:0]   pos0;
      entry_type          new_value;
   } ctrl_type;

endpackage

/* hdl/ilid_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on ilid_pkg for field widths.
`timescale 1ns / 1ps

interface ilid_req_if;
   logic                         valid;
   logic                         ready;
   logic [ilid_pkg::FUNC_W-1:0]  func;
   logic [ilid_pkg::POS_W-1:0]   position;
   ilid_pkg::entry_type          new_value;

   modport source (output valid, func, position, new_value, input ready);
   modport sink   (input valid, func, position, new_value, output ready);
endinterface

interface ilid_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   ilid_pkg::entry_type          read_value;
   logic [ilid_pkg::COUNT_W-1:0] count;

   modport source (output valid, status, read_value, count, input ready);
   modport sink   (input valid, status, read_value, count, output ready);
endinterface

/* hdl/indexed_list_insert_delete.sv */
// Indexed list top level: request decode, length register, a row of DEPTH
// cells and the response register. Depends on ilid_pkg, ilid_if.sv, ilid_cell
// and indexed_list_insert_delete_defines.svh.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit entries in a
// row of cells that all shift together, and a new request word is taken every
// cycle as long as the response word is consumed; the single response register
// sets that figure, and the request side stalls only while a response waits
// unread. Each request gives one response word with status, the entry read or
// removed, and the list length afterwards. Bad positions, insert into a full
// list, reads on an empty list and the unused function code return an error
// status with a zero value and change nothing.
`timescale 1ns / 1ps
`include "indexed_list_insert_delete_defines.svh"

module indexed_list_insert_delete #(
   parameter int DEPTH = ilid_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ilid_req_if.sink   req_chan,
   ilid_rsp_if.source rsp_chan
);

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((LEN_W > ilid_pkg::POS_W) ? LEN_W : ilid_pkg::POS_W) + 1;
   localparam int RD_N  = (DEPTH < 64) ? DEPTH : 64;
   localparam int RD_W  = $clog2(RD_N);

   logic [LEN_W-1:0]             len_ff;
   logic [LEN_W-1:0]             len_in;
   logic                         rsp_valid_ff;
   logic                         rsp_status_ff;
   ilid_pkg::entry_type          rsp_value_ff;
   logic [ilid_pkg::COUNT_W-1:0] rsp_count_ff;

   logic                         accept;
   logic                         ok;
   logic                         rd_ok;
   logic                         ins_ok;
   logic [CMP_W-1:0]             pos_ext;
   logic [CMP_W-1:0]             len_ext;
   logic [CMP_W-1:0]             len_next_ext;
   logic [ilid_pkg::POS_W-1:0]   pos_m1;
   ilid_pkg::entry_type          rd_value;
   ilid_pkg::entry_type          rsp_value;
   ilid_pkg::ctrl_type           ctrl;

   ilid_pkg::entry_type          entry_q [DEPTH];
   ilid_pkg::entry_type          left_d  [DEPTH];
   ilid_pkg::entry_type          right_d [DEPTH];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      pos_ext  = CMP_W'(req_chan.position);
      len_ext  = CMP_W'(len_ff);
      pos_m1   = req_chan.position - ilid_pkg::POS_W'(1);
      rd_value = entry_q[pos_m1[RD_W-1:0]];
      rd_ok    = (req_chan.position != '0) && (pos_ext <= len_ext);
      ins_ok   = (len_ext < CMP_W'(DEPTH)) && (req_chan.position != '0)
                 && (pos_ext <= len_ext + CMP_W'(1));
      ok        = 1'b0;
      len_in    = len_ff;
      rsp_value = '0;
      unique case (req_chan.func)
         ilid_pkg::OP_GET: begin
            ok = rd_ok;
            if (rd_ok) begin
               rsp_value = rd_value;
            end
         end
         ilid_pkg::OP_INSERT: begin
            ok = ins_ok;
            if (ins_ok) begin
               len_in = len_ff + LEN_W'(1);
            end
         end
         ilid_pkg::OP_DELETE: begin
            ok = rd_ok;
            if (rd_ok) begin
               rsp_value = rd_value;
               len_in    = len_ff - LEN_W'(1);
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      len_next_ext   = CMP_W'(len_in);
      ctrl.ins_en    = accept && ok && (req_chan.func == ilid_pkg::OP_INSERT);
      ctrl.del_en    = accept && ok && (req_chan.func == ilid_pkg::OP_DELETE);
      ctrl.pos0      = pos_m1;
      ctrl.new_value = req_chan.new_value;
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign left_d[g] = '0;
         end else begin : g_inner_l
            assign left_d[g] = entry_q[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_d[g] = '0;
         end else begin : g_inner_r
            assign right_d[g] = entry_q[g+1];
         end
         ilid_cell #(
            .IDX (g)
         ) u_cell (
            .clock   (clock),
            .ctrl    (ctrl),
            .left_d  (left_d[g]),
            .right_d (right_d[g]),
            .entry_q (entry_q[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            len_ff       <= len_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= !ok;
         rsp_value_ff  <= rsp_value;
         rsp_count_ff  <= len_next_ext[ilid_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.count      = rsp_count_ff;

   `ILID_ASSERT(a_len_bound, clock, reset, CMP_W'(len_ff) <= CMP_W'(DEPTH), "length above depth")
   `ILID_ASSERT(a_ins_grows, clock, reset, ctrl.ins_en |=> len_ff == $past(len_ff) + LEN_W'(1), "insert did not grow list")
   `ILID_ASSERT(a_err_hold, clock, reset, (accept && !ok) |=> $stable(len_ff), "error changed length")
   `ILID_ASSERT(a_err_zero, clock, reset, (rsp_valid_ff && rsp_status_ff) |-> (rsp_value_ff == '0), "error word carries a value")

endmodule

/* hdl/ilid_cell.sv */
// One storage cell of the list row: holds a single entry and loads from its
// left neighbor, its right neighbor or the new value. Depends on ilid_pkg.
`timescale 1ns / 1ps

module ilid_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  ilid_pkg::ctrl_type  ctrl,
   input  ilid_pkg::entry_type left_d,
   input  ilid_pkg::entry_type right_d,
   output ilid_pkg::entry_type entry_q
);

   ilid_pkg::entry_type entry_ff;
   ilid_pkg::entry_type entry_in;
   logic                at_pos;
   logic                past_pos;

   always_comb begin
      at_pos   = (int'(ctrl.pos0) == IDX);
      past_pos = (int'(ctrl.pos0) < IDX);
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (at_pos) begin
            entry_in = ctrl.new_value;
         end else if (past_pos) begin
            entry_in = left_d;
         end
      end else if (ctrl.del_en) begin
         if (at_pos || past_pos) begin
            entry_in = right_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

/* sim/tb_indexed_list_insert_delete.sv */
// Self-checking testbench for indexed_list_insert_delete: directed and random get, insert
// and delete words against a built-in list model, with random idling on both channels.
// Depends on ilid_pkg, the channel interfaces in ilid_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete;

   localparam int DEPTH = ilid_pkg::DEPTH_DEFAULT;
   localparam int ITEM_TARGET = 550;
   localparam int IDLE_LIMIT = 1000;
   localparam logic [ilid_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [ilid_pkg::FUNC_W-1:0] func;
      logic [ilid_pkg::POS_W-1:0]  position;
      ilid_pkg::entry_type         new_value;
   } req_word_type;

   typedef struct packed {
      logic                         status;
      ilid_pkg::entry_type          read_value;
      logic [ilid_pkg::COUNT_W-1:0] count;
   } rsp_word_type;

   typedef enum {SEG_GROW, SEG_SHRINK, SEG_MIXED} seg_mode_type;

   logic clock;
   logic reset;

   ilid_req_if req_bus ();
   ilid_rsp_if rsp_bus ();

   indexed_list_insert_delete #(.DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   req_word_type        request_backlog[$];
   rsp_word_type        pending_results[$];
   ilid_pkg::entry_type list_entries[DEPTH];
   int unsigned         list_len;
   int                  plan_len;
   int                  total_items;
   int                  sent_count;
   int                  got_count;
   int                  mismatch_count;
   int                  drv_wait;
   int                  rsp_hold;
   int                  idle_cycles;
   bit                  drv_free;
   req_word_type        next_word;
   rsp_word_type        exp_word;

   // Applies one request word to the list model and returns the response it must give.
   function automatic rsp_word_type apply_request(logic [ilid_pkg::FUNC_W-1:0] func,
                                                  logic [ilid_pkg::POS_W-1:0] pos,
                                                  ilid_pkg::entry_type value);
      rsp_word_type r;
      int k;
      r.status = 1'b1;
      r.read_value = '0;
      case (func)
         ilid_pkg::OP_GET: begin
            if (pos >= 1 && pos <= list_len) begin
               r.status = 1'b0;
               r.read_value = list_entries[pos-1];
            end
         end
         ilid_pkg::OP_INSERT: begin
            if (list_len < DEPTH && pos >= 1 && pos <= list_len + 1) begin
               for (k = list_len; k >= pos; k--) begin
                  list_entries[k] = list_entries[k-1];
               end
               list_entries[pos-1] = value;
               list_len++;
               r.status = 1'b0;
            end
         end
         ilid_pkg::OP_DELETE: begin
            if (pos >= 1 && pos <= list_len) begin
               r.read_value = list_entries[pos-1];
               for (k = pos; k < list_len; k++) begin
                  list_entries[k-1] = list_entries[k];
               end
               list_len--;
               r.status = 1'b0;
            end
         end
         default: ;
      endcase
      r.count = list_len[ilid_pkg::COUNT_W-1:0];
      return r;
   endfunction

   task automatic queue_request(input logic [ilid_pkg::FUNC_W-1:0] func, input int pos,
                                input ilid_pkg::entry_type value);
      req_word_type w;
      w.func = func;
      w.position = pos[ilid_pkg::POS_W-1:0];
      w.new_value = value;
      request_backlog.push_back(w);
      if (func == ilid_pkg::OP_INSERT && plan_len < DEPTH && w.position >= 1
          && w.position <= plan_len + 1) begin
         plan_len++;
      end else if (func == ilid_pkg::OP_DELETE && w.position >= 1
                   && w.position <= plan_len) begin
         plan_len--;
      end
   endtask

   function automatic ilid_pkg::entry_type pick_value();
      int roll;
      roll = $urandom_range(0, 19);
      case (roll)
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Mostly legal positions up to last_pos, with the edges and stray values mixed in.
   function automatic int pick_position(int last_pos);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0 || last_pos < 1) return $urandom_range(0, 63);
      if (roll == 1) return ($urandom_range(0, 1) != 0) ? 1 : last_pos;
      if (roll == 2) return last_pos + 1;
      return $urandom_range(1, last_pos);
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      seg_mode_type seg_mode;
      int seg_left;
      int roll;
      int ins_pct;
      int del_pct;
      logic [ilid_pkg::FUNC_W-1:0] func;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = ilid_pkg::OP_GET;
      req_bus.position = '0;
      req_bus.new_value = '0;
      rsp_bus.ready = 1'b0;
      plan_len = 0;
      list_len = 0;
      foreach (list_entries[i]) list_entries[i] = '0;

      queue_request(ilid_pkg::OP_GET, 1, '0);
      queue_request(ilid_pkg::OP_DELETE, 1, '0);
      queue_request(ilid_pkg::OP_INSERT, 0, 32'sh12345678);
      queue_request(ilid_pkg::OP_INSERT, 2, 32'sh12345678);
      queue_request(ilid_pkg::OP_INSERT, 1, 32'sh7fffffff);
      queue_request(ilid_pkg::OP_INSERT, 2, 32'sh80000000);
      queue_request(ilid_pkg::OP_INSERT, 1, '1);
      queue_request(ilid_pkg::OP_INSERT, 2, '0);
      for (int p = 1; p <= 4; p++) queue_request(ilid_pkg::OP_GET, p, $urandom());
      queue_request(ilid_pkg::OP_GET, 5, '0);
      queue_request(ilid_pkg::OP_GET, 63, '0);
      queue_request(ilid_pkg::OP_GET, 0, '0);
      queue_request(OP_UNUSED, 1, '1);
      queue_request(ilid_pkg::OP_DELETE, 4, '0);
      queue_request(ilid_pkg::OP_DELETE, 1, '0);
      queue_request(ilid_pkg::OP_GET, 1, '0);
      queue_request(ilid_pkg::OP_GET, 2, '0);
      queue_request(ilid_pkg::OP_DELETE, 63, '0);
      queue_request(ilid_pkg::OP_DELETE, 0, '0);
      queue_request(ilid_pkg::OP_INSERT, 63, $urandom());

      while (plan_len < DEPTH) queue_request(ilid_pkg::OP_INSERT,
                                             $urandom_range(1, plan_len + 1), pick_value());
      queue_request(ilid_pkg::OP_INSERT, 1, pick_value());
      queue_request(ilid_pkg::OP_INSERT, DEPTH + 1, pick_value());
      queue_request(ilid_pkg::OP_GET, DEPTH, $urandom());
      queue_request(ilid_pkg::OP_GET, DEPTH + 1, $urandom());
      queue_request(ilid_pkg::OP_DELETE, DEPTH, $urandom());

      while (request_backlog.size() < ITEM_TARGET) begin
         seg_mode = seg_mode_type'($urandom_range(0, 2));
         seg_left = $urandom_range(20, 60);
         case (seg_mode)
            SEG_GROW: begin
               ins_pct = 70;
               del_pct = 15;
            end
            SEG_SHRINK: begin
               ins_pct = 15;
               del_pct = 70;
            end
            default: begin
               ins_pct = 35;
               del_pct = 30;
            end
         endcase
         repeat (seg_left) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) func = OP_UNUSED;
            else if (roll < 2 + ins_pct) func = ilid_pkg::OP_INSERT;
            else if (roll < 2 + ins_pct + del_pct) func = ilid_pkg::OP_DELETE;
            else func = ilid_pkg::OP_GET;
            queue_request(func,
                          pick_position(func == ilid_pkg::OP_INSERT ? plan_len + 1 : plan_len),
                          pick_value());
         end
      end
      total_items = request_backlog.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (sent_count == total_items && pending_results.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Request driver: after each accepted word it idles for a set or random wait.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         drv_wait = $urandom_range(0, 6);
      end else begin
         drv_free = !req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            pending_results.push_back(apply_request(req_bus.func, req_bus.position,
                                                    req_bus.new_value));
            sent_count++;
            drv_free = 1'b1;
            if ((sent_count >= 120 && sent_count < 180)
                || (sent_count >= 420 && sent_count < 470))
               drv_wait = 0;
            else
               drv_wait = $urandom_range(0, 6);
         end
         if (drv_free) begin
            if (drv_wait == 0 && request_backlog.size() > 0) begin
               next_word = request_backlog.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.func <= next_word.func;
               req_bus.position <= next_word.position;
               req_bus.new_value <= next_word.new_value;
            end else begin
               req_bus.valid <= 1'b0;
               if (drv_wait > 0) drv_wait--;
            end
         end
      end
   end

   // Response monitor: checks every accepted word, then stalls for a set or random wait.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = $urandom_range(0, 6);
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected word, expected none, got status %0b value %0d count %0d",
                        $time, rsp_bus.status, $signed(rsp_bus.read_value), rsp_bus.count);
               mismatch_count++;
            end else begin
               exp_word = pending_results.pop_front();
               if (rsp_bus.status !== exp_word.status) begin
                  $display("%0t: status mismatch, expected %0b, got %0b",
                           $time, exp_word.status, rsp_bus.status);
                  mismatch_count++;
               end
               if (rsp_bus.read_value !== exp_word.read_value) begin
                  $display("%0t: read_value mismatch, expected %0d, got %0d",
                           $time, $signed(exp_word.read_value), $signed(rsp_bus.read_value));
                  mismatch_count++;
               end
               if (rsp_bus.count !== exp_word.count) begin
                  $display("%0t: count mismatch, expected %0d, got %0d",
                           $time, exp_word.count, rsp_bus.count);
                  mismatch_count++;
               end
            end
            got_count++;
            if (got_count == 150) rsp_hold = 80;
            else if (got_count >= 260 && got_count < 330) rsp_hold = 0;
            else rsp_hold = $urandom_range(0, 6);
         end
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule
